### src/ksd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksd_pkg
// Shared types and constants of the plucked string delay loop unit.
// ----------------------------------------------------------------------------
package ksd_pkg;

  localparam int MAX_LENGTH_DEF = 1024;
  localparam int SAMPLE_W       = 16;
  localparam int GAIN_W         = 16;
  localparam int LEN_W          = 11;
  localparam int TICK_W         = 32;
  localparam int CFG_IDX_W      = 8;
  localparam int CFG_DATA_W     = 32;

  // scaled sum is divided by 2^QSHIFT, or 2^(QSHIFT+1) in drum mode
  localparam int QSHIFT         = GAIN_W + 1;

  localparam logic [LEN_W-1:0]  LEN_RST  = LEN_W'(100);
  localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(65274);

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_TICK  = 2'd0;
  localparam mode_t MODE_LOAD  = 2'd1;
  localparam mode_t MODE_CLEAR = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_STRING_LENGTH = CFG_IDX_W'(0);
  localparam cfg_idx_t CFG_GAIN_Q16      = CFG_IDX_W'(1);
  localparam cfg_idx_t CFG_DRUM_MODE     = CFG_IDX_W'(2);

endpackage

### src/ksd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksd_in_if
// Input item channel: mode and excitation sample.
// ----------------------------------------------------------------------------
interface ksd_in_if;
  logic                                valid;
  logic                                ready;
  ksd_pkg::mode_t                      mode;
  logic signed [ksd_pkg::SAMPLE_W-1:0] sample_in;

  modport source (output valid, output mode, output sample_in, input ready);
  modport sink (input valid, input mode, input sample_in, output ready);
endinterface

### src/ksd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksd_out_if
// Result channel: front sample, fill level, tick count and error flag.
// ----------------------------------------------------------------------------
interface ksd_out_if #(
  parameter int FILL_W = ksd_pkg::LEN_W
);
  logic                                valid;
  logic                                ready;
  logic signed [ksd_pkg::SAMPLE_W-1:0] sample_out;
  logic [FILL_W-1:0]                   fill_level;
  logic [ksd_pkg::TICK_W-1:0]          tick_count;
  logic                                error;

  modport source (output valid, output sample_out, output fill_level,
                  output tick_count, output error, input ready);
  modport sink (input valid, input sample_out, input fill_level,
                input tick_count, input error, output ready);
endinterface

### src/ksd_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ksd_cfg_if;
  logic                             valid;
  logic                             ready;
  ksd_pkg::cfg_idx_t                index;
  logic [ksd_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### src/ksd_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksd_ring
// Single-port sample memory of the delay ring, registered read data.
// ----------------------------------------------------------------------------
module ksd_ring #(
  parameter int DEPTH = ksd_pkg::MAX_LENGTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                addr,
  input  logic [ksd_pkg::SAMPLE_W-1:0] wdata,
  output logic [ksd_pkg::SAMPLE_W-1:0] rdata
);

  logic [ksd_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic [ksd_pkg::SAMPLE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### src/ksd_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksd_mul
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ksd_mul #(
  parameter int A_W = ksd_pkg::SAMPLE_W + 1,
  parameter int B_W = ksd_pkg::GAIN_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [A_W-1:0]   a,
  input  logic [B_W-1:0]   b,
  output logic             done,
  output logic [A_W+B_W-1:0] product
);

  localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(B_W - 1);

  logic [A_W-1:0]   a_r;
  logic [A_W:0]     hi_r;
  logic [B_W-1:0]   lo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;
  logic [A_W:0]     add;

  assign add = hi_r + (lo_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (run_r) begin
      hi_r <= {1'b0, add[A_W:1]};
      lo_r <= {add[0], lo_r[B_W-1:1]};
    end
  end

  assign done    = done_r;
  assign product = {hi_r[A_W-1:0], lo_r};

endmodule

### src/plucked_string_delay_loop_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plucked_string_delay_loop_unit
// Plucked string synthesizer on a ring delay line of signed 16-bit samples.
// in_chan takes one item per beat: mode tick, load (append sample_in) or
// clear. out_chan returns exactly one result beat per item: front sample,
// fill level, tick count and error flag. cfg_chan writes string_length,
// gain_q16 and drum_mode; it is always ready. The user must write it only
// while idle; the block itself does not enforce this. Load, clear and
// refused items pass through the S_DONE state into the result register. A
// tick steps through a ring read, the shift-add multiplier (one gain bit per
// cycle), its done flag, a ring write and the result load. One item is
// worked on at a time; in_chan.ready is high only while the sequencer is
// idle, so a new item is taken only once the last result is loaded into the
// output register. The front sample is kept in a register so status needs
// no ring read. A stalled out_chan holds its beat; the finished next result
// waits in the sequencer until the output register frees up.
// Reset clears fill, head, tick count and the registers to their defaults;
// ring contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module plucked_string_delay_loop_unit #(
  parameter int MAX_LENGTH = ksd_pkg::MAX_LENGTH_DEF,
  parameter int FILL_W     = $clog2(MAX_LENGTH + 1)
) (
  input logic      clk,
  input logic      rst_n,
  ksd_in_if.sink   in_chan,
  ksd_out_if.source out_chan,
  ksd_cfg_if.sink  cfg_chan
);

  localparam int SW   = ksd_pkg::SAMPLE_W;
  localparam int AW   = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int XW   = AW + 1;
  localparam int CW   = (FILL_W > ksd_pkg::LEN_W) ? FILL_W : ksd_pkg::LEN_W;
  localparam int PW   = SW + 1 + ksd_pkg::GAIN_W;
  localparam logic [XW-1:0] MAX_X = XW'(MAX_LENGTH);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_LENGTH);
  localparam logic [CW-1:0] MIN_C = CW'(2);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_MUL   = 5'b00100,
    S_WRITE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [ksd_pkg::LEN_W-1:0]  len_r;
  logic [ksd_pkg::GAIN_W-1:0] gain_r;
  logic                       drum_r;

  logic [AW-1:0]             head_r, head_nxt;
  logic [FILL_W-1:0]         fill_r, fill_nxt;
  logic [ksd_pkg::TICK_W-1:0] tick_r, tick_nxt;
  logic [SW-1:0]             front_r, front_nxt;
  logic [SW-1:0]             next_r, next_nxt;
  logic                      neg_r, neg_nxt;
  logic                      err_r, err_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [SW-1:0]             out_sample_r, out_sample_nxt;
  logic [FILL_W-1:0]         out_fill_r, out_fill_nxt;
  logic [ksd_pkg::TICK_W-1:0] out_tick_r, out_tick_nxt;
  logic                      out_err_r, out_err_nxt;

  logic                      in_accept;
  logic [CW-1:0]             cap;
  logic [CW-1:0]             len_c;
  logic                      full;

  logic [XW-1:0]             inc_sum, fill_sum;
  logic [XW-1:0]             inc_wrap, fill_wrap;
  logic [AW-1:0]             head_inc, slot_fill;

  logic                      ring_we;
  logic [AW-1:0]             ring_addr;
  logic [SW-1:0]             ring_wdata;
  logic [SW-1:0]             ring_rdata;

  logic [SW:0]               pair_sum;
  logic [SW:0]               pair_mag;
  logic                      mul_start;
  logic                      mul_done;
  logic [PW-1:0]             mul_prod;
  logic [PW-1:0]             prod_sh;
  logic [SW-1:0]             quot;
  logic [SW-1:0]             new_sample;

  assign in_accept     = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;

  // capacity: string_length saturated to [2, MAX_LENGTH]
  assign len_c = CW'(len_r);
  always_comb begin
    priority if (len_c < MIN_C) begin
      cap = MIN_C;
    end else if (len_c > MAX_C) begin
      cap = MAX_C;
    end else begin
      cap = len_c;
    end
  end
  assign full = (CW'(fill_r) >= cap);

  // ring slot arithmetic
  assign inc_sum   = {1'b0, head_r} + XW'(1);
  assign inc_wrap  = (inc_sum >= MAX_X) ? (inc_sum - MAX_X) : inc_sum;
  assign head_inc  = inc_wrap[AW-1:0];
  assign fill_sum  = {1'b0, head_r} + XW'(fill_r);
  assign fill_wrap = (fill_sum >= MAX_X) ? (fill_sum - MAX_X) : fill_sum;
  assign slot_fill = fill_wrap[AW-1:0];

  assign ring_addr = (state_r == S_IDLE && in_chan.mode == ksd_pkg::MODE_TICK) ?
                     head_inc : slot_fill;

  ksd_ring #(
    .DEPTH (MAX_LENGTH),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .addr  (ring_addr),
    .wdata (ring_wdata),
    .rdata (ring_rdata)
  );

  // decay arithmetic
  assign pair_sum = {front_r[SW-1], front_r} + {ring_rdata[SW-1], ring_rdata};
  assign pair_mag = pair_sum[SW] ? (~pair_sum + 1'b1) : pair_sum;

  ksd_mul #(
    .A_W (SW + 1),
    .B_W (ksd_pkg::GAIN_W)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (pair_mag),
    .b       (gain_r),
    .done    (mul_done),
    .product (mul_prod)
  );

  assign prod_sh    = drum_r ? (mul_prod >> (ksd_pkg::QSHIFT + 1)) :
                               (mul_prod >> ksd_pkg::QSHIFT);
  assign quot       = prod_sh[SW-1:0];
  assign new_sample = neg_r ? (~quot + 1'b1) : quot;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    fill_nxt       = fill_r;
    tick_nxt       = tick_r;
    front_nxt      = front_r;
    next_nxt       = next_r;
    neg_nxt        = neg_r;
    err_nxt        = err_r;
    ring_we        = 1'b0;
    ring_wdata     = in_chan.sample_in;
    mul_start      = 1'b0;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_sample_nxt = out_sample_r;
    out_fill_nxt   = out_fill_r;
    out_tick_nxt   = out_tick_r;
    out_err_nxt    = out_err_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          err_nxt   = 1'b0;
          state_nxt = S_DONE;
          unique case (in_chan.mode)
            ksd_pkg::MODE_CLEAR: begin
              fill_nxt = '0;
              head_nxt = '0;
            end
            ksd_pkg::MODE_LOAD: begin
              if (full) begin
                err_nxt = 1'b1;
              end else begin
                ring_we  = 1'b1;
                fill_nxt = fill_r + 1'b1;
                if (fill_r == '0) begin
                  front_nxt = in_chan.sample_in;
                end
              end
            end
            ksd_pkg::MODE_TICK: begin
              if (fill_r < FILL_W'(2)) begin
                err_nxt = 1'b1;
              end else begin
                state_nxt = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        next_nxt  = ring_rdata;
        neg_nxt   = pair_sum[SW];
        mul_start = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (mul_done) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        ring_we    = 1'b1;
        ring_wdata = new_sample;
        head_nxt   = head_inc;
        front_nxt  = next_r;
        tick_nxt   = tick_r + 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = (fill_r != '0) ? front_r : '0;
          out_fill_nxt   = fill_r;
          out_tick_nxt   = tick_r;
          out_err_nxt    = err_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      tick_r      <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
      len_r       <= ksd_pkg::LEN_RST;
      gain_r      <= ksd_pkg::GAIN_RST;
      drum_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      tick_r      <= tick_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_chan.valid && cfg_chan.ready) begin
        unique case (cfg_chan.index)
          ksd_pkg::CFG_STRING_LENGTH: len_r  <= cfg_chan.data[ksd_pkg::LEN_W-1:0];
          ksd_pkg::CFG_GAIN_Q16:      gain_r <= cfg_chan.data[ksd_pkg::GAIN_W-1:0];
          ksd_pkg::CFG_DRUM_MODE:     drum_r <= cfg_chan.data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    front_r      <= front_nxt;
    next_r       <= next_nxt;
    neg_r        <= neg_nxt;
    out_sample_r <= out_sample_nxt;
    out_fill_r   <= out_fill_nxt;
    out_tick_r   <= out_tick_nxt;
    out_err_r    <= out_err_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.sample_out = out_sample_r;
  assign out_chan.fill_level = out_fill_r;
  assign out_chan.tick_count = out_tick_r;
  assign out_chan.error      = out_err_r;

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_chan.ready)
    else $error("input accepted while an item is in flight");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(fill_r) <= MAX_C)
    else $error("fill level beyond ring depth");

  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_MUL))
    else $error("multiplier finished outside the multiply step");

  a_tick_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |=> (tick_r == $past(tick_r) + 1'b1))
    else $error("tick write without tick count advance");

endmodule

### sim/plucked_string_delay_loop_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plucked_string_delay_loop_unit_tb
// Self-checking bench for the plucked string delay loop unit. A queue-fed
// driver offers tick, load, clear and spare-mode beats. A monitor keeps its
// own copy of the ring, head, fill, tick count and registers, predicts every
// status beat and compares each one field by field. Phases walk through ring
// lengths from below the minimum to above the maximum, gain extremes, both
// divide modes, a ring filled to 1024 samples and a fill left above a
// lowered capacity. Both sides idle at random, and the receiver once holds
// off long enough to back the block up.
// ----------------------------------------------------------------------------
module plucked_string_delay_loop_unit_tb;

  localparam ksd_pkg::mode_t    MODE_SPARE     = 2'd3;
  localparam logic signed [15:0] SAMPLE_MAX    = 16'sh7fff;
  localparam logic signed [15:0] SAMPLE_MIN    = 16'sh8000;
  localparam int                RING_DEPTH     = 1024;
  localparam int                SETTLE_CYCLES  = 40;
  localparam int                LONG_HOLD      = 400;
  localparam int                WATCHDOG_LIMIT = 4000;

  typedef struct {
    ksd_pkg::mode_t     mode;
    logic signed [15:0] sample;
  } pluck_beat_t;

  typedef struct {
    logic signed [15:0] front;
    logic [10:0]        fill;
    logic [31:0]        ticks;
    logic               err;
  } string_status_t;

  logic clk = 1'b0;
  logic rst_n;

  ksd_in_if  in_bus ();
  ksd_out_if out_bus ();
  ksd_cfg_if cfg_bus ();

  plucked_string_delay_loop_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the string state and registers
  logic signed [15:0] ring [0:RING_DEPTH-1];
  logic [9:0]         ring_head;
  logic [10:0]        ring_fill;
  logic [31:0]        tick_total;
  logic [10:0]        len_reg;
  logic [15:0]        gain_reg;
  logic               drum_reg;

  pluck_beat_t    pending_beats [$];
  string_status_t due_status [$];
  pluck_beat_t    next_beat;
  string_status_t due;

  logic in_taken = 1'b0;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   hold_kick = 1'b0;
  bit   hold_seen = 1'b0;
  int   hold_left = 0;
  int   idle_cycles = 0;

  int mismatches = 0;
  int beats_in = 0;
  int results_checked = 0;
  int refused_seen = 0;
  int peak_fill = 0;
  int phases_run = 0;

  function automatic logic [10:0] string_capacity();
    if (len_reg < 11'd2) return 11'd2;
    if (len_reg > 11'(RING_DEPTH)) return 11'(RING_DEPTH);
    return len_reg;
  endfunction

  function automatic logic signed [15:0] damped_sum(input logic signed [15:0] a,
                                                    input logic signed [15:0] b);
    logic [16:0] sum;
    logic [16:0] mag;
    logic [32:0] prod;
    logic [32:0] q;
    sum  = {a[15], a} + {b[15], b};
    mag  = sum[16] ? -sum : sum;
    prod = 33'(mag) * 33'(gain_reg);
    q    = drum_reg ? (prod >> (ksd_pkg::QSHIFT + 1)) : (prod >> ksd_pkg::QSHIFT);
    return sum[16] ? -q[15:0] : q[15:0];
  endfunction

  function automatic string_status_t pluck_step(input ksd_pkg::mode_t m,
                                                input logic signed [15:0] s);
    string_status_t     r;
    logic [9:0]         slot;
    logic [9:0]         nxt;
    logic signed [15:0] nv;
    r.err = 1'b0;
    case (m)
      ksd_pkg::MODE_CLEAR: begin
        ring_fill = '0;
        ring_head = '0;
      end
      ksd_pkg::MODE_LOAD: begin
        if (ring_fill >= string_capacity()) begin
          r.err = 1'b1;
        end else begin
          slot = 10'(ring_head + ring_fill);
          ring[slot] = s;
          ring_fill = ring_fill + 11'd1;
        end
      end
      ksd_pkg::MODE_TICK: begin
        if (ring_fill < 11'd2) begin
          r.err = 1'b1;
        end else begin
          nxt = ring_head + 10'd1;
          nv = damped_sum(ring[ring_head], ring[nxt]);
          ring_head = nxt;
          slot = 10'(ring_head + ring_fill - 11'd1);
          ring[slot] = nv;
          tick_total = tick_total + 32'd1;
        end
      end
      default: begin
      end
    endcase
    r.front = (ring_fill != '0) ? ring[ring_head] : 16'sd0;
    r.fill  = ring_fill;
    r.ticks = tick_total;
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_taken) begin
      if (pending_beats.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        next_beat = pending_beats.pop_front();
        in_bus.valid     <= 1'b1;
        in_bus.mode      <= next_beat.mode;
        in_bus.sample_in <= next_beat.sample;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_kick != hold_seen) begin
      hold_seen     <= hold_kick;
      hold_left     <= LONG_HOLD;
      out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // monitor: registers, prediction per input beat, check per result beat
  always @(posedge clk) begin
    in_taken <= rst_n && in_bus.valid && in_bus.ready;
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          ksd_pkg::CFG_STRING_LENGTH: len_reg  = cfg_bus.data[ksd_pkg::LEN_W-1:0];
          ksd_pkg::CFG_GAIN_Q16:      gain_reg = cfg_bus.data[ksd_pkg::GAIN_W-1:0];
          ksd_pkg::CFG_DRUM_MODE:     drum_reg = cfg_bus.data[0];
          default: begin
          end
        endcase
      end
      if (in_bus.valid && in_bus.ready) begin
        due = pluck_step(in_bus.mode, in_bus.sample_in);
        due_status = {due_status, due};
        beats_in++;
        if (due.err) refused_seen++;
        if (int'(due.fill) > peak_fill) peak_fill = due.fill;
      end
      if (out_bus.valid && out_bus.ready) begin
        if (due_status.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result: sample %0d fill %0d ticks %0d error %0b", $time,
                   $signed(out_bus.sample_out), out_bus.fill_level, out_bus.tick_count,
                   out_bus.error);
        end else begin
          due = due_status.pop_front();
          results_checked++;
          if (out_bus.sample_out !== due.front) begin
            mismatches++;
            $display("%0t sample_out expected %0d actual %0d", $time, $signed(due.front),
                     $signed(out_bus.sample_out));
          end
          if (out_bus.fill_level !== due.fill) begin
            mismatches++;
            $display("%0t fill_level expected %0d actual %0d", $time, due.fill,
                     out_bus.fill_level);
          end
          if (out_bus.tick_count !== due.ticks) begin
            mismatches++;
            $display("%0t tick_count expected %0d actual %0d", $time, due.ticks,
                     out_bus.tick_count);
          end
          if (out_bus.error !== due.err) begin
            mismatches++;
            $display("%0t error expected %0b actual %0b", $time, due.err, out_bus.error);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t no beat for %0d cycles, %0d results outstanding", $time,
               WATCHDOG_LIMIT, due_status.size());
      $display("plucked_string_delay_loop_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(7, 0))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return 16'($urandom_range(3, 0)) - 16'sd2;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void queue_beat(input ksd_pkg::mode_t m, input logic signed [15:0] s);
    pluck_beat_t b;
    b.mode   = m;
    b.sample = s;
    pending_beats = {pending_beats, b};
  endfunction

  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_bus.valid || due_status.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [10:0] len, input logic [15:0] gain,
                              input logic drum);
    ksd_pkg::cfg_idx_t reg_ids [3] = '{ksd_pkg::CFG_STRING_LENGTH, ksd_pkg::CFG_GAIN_Q16,
                                       ksd_pkg::CFG_DRUM_MODE};
    logic [31:0] vals [3];
    vals[0] = {21'($urandom), len};
    vals[1] = {16'($urandom), gain};
    vals[2] = {31'($urandom), drum};
    for (int k = 0; k < 3; k++) begin
      @(negedge clk);
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= reg_ids[k];
      cfg_bus.data  <= vals[k];
      @(posedge clk);
      while (!cfg_bus.ready) @(posedge clk);
    end
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [10:0] len, input logic [15:0] gain,
                           input logic drum, input int n_items, input int burst,
                           input bit keep_ring);
    int made;
    int n_load;
    int n_tick;
    made = 0;
    wait_idle();
    write_config(len, gain, drum);
    @(posedge clk);
    phases_run++;
    if (!keep_ring) queue_beat(ksd_pkg::MODE_CLEAR, pick_sample());
    while (made < n_items) begin
      if ($urandom_range(9, 0) < 2) begin
        queue_beat(ksd_pkg::mode_t'($urandom_range(3, 0)), pick_sample());
        made++;
      end else begin
        if ($urandom_range(3, 0) == 0) begin
          queue_beat(ksd_pkg::MODE_CLEAR, pick_sample());
          made++;
        end
        n_load = $urandom_range(burst, 1);
        n_tick = $urandom_range(2 * burst, 1);
        repeat (n_load) queue_beat(ksd_pkg::MODE_LOAD, pick_sample());
        repeat (n_tick) queue_beat(ksd_pkg::MODE_TICK, pick_sample());
        made += n_load + n_tick;
      end
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.mode       = ksd_pkg::MODE_TICK;
    in_bus.sample_in  = '0;
    out_bus.ready     = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = ksd_pkg::CFG_STRING_LENGTH;
    cfg_bus.data      = '0;
    ring_head         = '0;
    ring_fill         = '0;
    tick_total        = '0;
    len_reg           = ksd_pkg::LEN_RST;
    gain_reg          = ksd_pkg::GAIN_RST;
    drum_reg          = 1'b0;
    send_idle_pct     = 30;
    recv_idle_pct     = 45;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, on the reset register values
    queue_beat(ksd_pkg::MODE_CLEAR, SAMPLE_MAX);
    queue_beat(ksd_pkg::MODE_TICK, 16'sd0);
    queue_beat(MODE_SPARE, SAMPLE_MIN);
    queue_beat(ksd_pkg::MODE_LOAD, SAMPLE_MAX);
    queue_beat(ksd_pkg::MODE_TICK, 16'sd0);
    queue_beat(ksd_pkg::MODE_LOAD, SAMPLE_MAX);
    queue_beat(ksd_pkg::MODE_TICK, -16'sd1);
    queue_beat(ksd_pkg::MODE_LOAD, SAMPLE_MIN);
    queue_beat(ksd_pkg::MODE_LOAD, SAMPLE_MIN);
    queue_beat(ksd_pkg::MODE_TICK, 16'sd0);
    queue_beat(ksd_pkg::MODE_TICK, 16'sd0);
    queue_beat(ksd_pkg::MODE_LOAD, 16'sd0);
    queue_beat(ksd_pkg::MODE_LOAD, -16'sd1);
    queue_beat(ksd_pkg::MODE_LOAD, 16'sd1);
    queue_beat(ksd_pkg::MODE_TICK, SAMPLE_MAX);
    queue_beat(ksd_pkg::MODE_TICK, SAMPLE_MIN);
    queue_beat(ksd_pkg::MODE_TICK, 16'sd0);
    queue_beat(MODE_SPARE, SAMPLE_MAX);
    queue_beat(ksd_pkg::MODE_CLEAR, 16'sd0);
    queue_beat(ksd_pkg::MODE_TICK, 16'sd0);
    queue_beat(ksd_pkg::MODE_LOAD, 16'sh5555);
    queue_beat(ksd_pkg::MODE_LOAD, 16'shaaaa);
    queue_beat(ksd_pkg::MODE_TICK, 16'sd0);

    run_phase(11'd2, 16'hffff, 1'b0, 10, 3, 1'b0);
    run_phase(11'd0, 16'h0000, 1'b1, 8, 3, 1'b0);
    run_phase(11'd17, 16'($urandom), 1'b1, 20, 6, 1'b0);
    hold_kick <= ~hold_kick;
    run_phase(11'd40, 16'hffff, 1'b1, 20, 8, 1'b0);

    send_idle_pct = 45;
    recv_idle_pct = 30;
    // capacity drops below the fill left by the previous phase
    run_phase(11'd5, 16'h0001, 1'b0, 8, 4, 1'b1);
    run_phase(11'd1, 16'($urandom), 1'($urandom_range(1, 0)), 8, 3, 1'b0);
    run_phase(11'h7ff, 16'hffff, 1'b0, 0, 1, 1'b0);
    for (int k = 0; k < RING_DEPTH + 2; k++) queue_beat(ksd_pkg::MODE_LOAD, pick_sample());
    repeat (10) queue_beat(ksd_pkg::MODE_TICK, pick_sample());
    run_phase(11'd3, ksd_pkg::GAIN_RST, 1'b1, 8, 3, 1'b1);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(11'd1024, 16'($urandom), 1'b0, 15, 6, 1'b0);
    run_phase(11'd100, 16'hffff, 1'b1, 15, 6, 1'b0);

    wait_idle();
    $display("covered %0d beats over %0d register settings, %0d results checked",
             beats_in, phases_run, results_checked);
    $display("%0d ticks, %0d refused beats, deepest fill %0d", tick_total, refused_seen,
             peak_fill);
    if (mismatches == 0) begin
      $display("plucked_string_delay_loop_unit regression: pass");
    end else begin
      $display("plucked_string_delay_loop_unit regression: fail");
    end
    $finish;
  end

endmodule

### files.f
src/ksd_pkg.sv
src/ksd_in_if.sv
src/ksd_out_if.sv
src/ksd_cfg_if.sv
src/ksd_ring.sv
src/ksd_mul.sv
src/plucked_string_delay_loop_unit.sv
sim/plucked_string_delay_loop_unit_tb.sv
